// ===== hw/rtl/wnpm_pkg.sv =====
// weighted nearest palette match: shared types and constants
// used by every module of the block, no dependencies
`timescale 1ns / 1ps

package wnpm_pkg;

  localparam int unsigned CH_BITS    = 6;
  localparam int unsigned SQ_BITS    = 2 * CH_BITS;
  localparam int unsigned WGT_BITS   = 8;
  localparam int unsigned PROD_BITS  = SQ_BITS + WGT_BITS;
  localparam int unsigned DIST_BITS  = 22;
  localparam int unsigned IDX_BITS   = 8;
  localparam int unsigned ENTRY_BITS = 3 * CH_BITS;
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam logic [DIST_BITS-1:0] MAX_DIST = 22'd3036285;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_MATCH = 1'b1
  } func_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_RED_WEIGHT   = 2'd0,
    REG_GREEN_WEIGHT = 2'd1,
    REG_BLUE_WEIGHT  = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_DRAIN = 2'd2
  } state_t;

  typedef struct packed {
    logic [WGT_BITS-1:0] red;
    logic [WGT_BITS-1:0] green;
    logic [WGT_BITS-1:0] blue;
  } weights_t;

  typedef struct packed {
    logic [CH_BITS-1:0] red;
    logic [CH_BITS-1:0] green;
    logic [CH_BITS-1:0] blue;
  } rgb6_t;

  // travels with each palette entry through the distance pipeline
  typedef struct packed {
    logic                valid;
    logic                first;
    logic                last;
    logic [IDX_BITS-1:0] idx;
  } tag_t;

  typedef struct packed {
    tag_t                 tag;
    logic [PROD_BITS-1:0] red;
    logic [PROD_BITS-1:0] green;
    logic [PROD_BITS-1:0] blue;
  } prod_t;

endpackage

// ===== hw/rtl/wnpm_palette_ram.sv =====
// target palette storage: one write port, one read port, registered read data
// depends on wnpm_pkg
`timescale 1ns / 1ps

module wnpm_palette_ram
  import wnpm_pkg::*;
#(
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  rgb6_t                    wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output rgb6_t                    rdata
);

  rgb6_t mem [DEPTH];
  rgb6_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/wnpm_dist.sv =====
// distance pipeline: squared channel differences, then weighted products
// depends on wnpm_pkg
`timescale 1ns / 1ps

module wnpm_dist
  import wnpm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  tag_t     tag_in,
  input  rgb6_t    entry,
  input  rgb6_t    source,
  input  weights_t weights,
  output prod_t    prod_out
);

  logic [CH_BITS-1:0] dr, dg, db;
  tag_t               sq_tag_r;
  logic [SQ_BITS-1:0] sq_r_r, sq_g_r, sq_b_r;
  prod_t              prod_r;

  always_comb begin
    dr = (source.red   > entry.red)   ? source.red   - entry.red   : entry.red   - source.red;
    dg = (source.green > entry.green) ? source.green - entry.green : entry.green - source.green;
    db = (source.blue  > entry.blue)  ? source.blue  - entry.blue  : entry.blue  - source.blue;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_tag_r.valid     <= 1'b0;
      prod_r.tag.valid   <= 1'b0;
    end else begin
      sq_tag_r.valid     <= tag_in.valid;
      prod_r.tag.valid   <= sq_tag_r.valid;
    end

    sq_tag_r.first <= tag_in.first;
    sq_tag_r.last  <= tag_in.last;
    sq_tag_r.idx   <= tag_in.idx;
    sq_r_r         <= SQ_BITS'(dr * dr);
    sq_g_r         <= SQ_BITS'(dg * dg);
    sq_b_r         <= SQ_BITS'(db * db);

    prod_r.tag.first <= sq_tag_r.first;
    prod_r.tag.last  <= sq_tag_r.last;
    prod_r.tag.idx   <= sq_tag_r.idx;
    prod_r.red       <= PROD_BITS'(weights.red   * sq_r_r);
    prod_r.green     <= PROD_BITS'(weights.green * sq_g_r);
    prod_r.blue      <= PROD_BITS'(weights.blue  * sq_b_r);
  end

  assign prod_out = prod_r;

endmodule

// ===== hw/rtl/weighted_nearest_palette_match.sv =====
// weighted nearest palette match, top level: control, weights, best tracking
// depends on wnpm_pkg, wnpm_palette_ram, wnpm_dist
`timescale 1ns / 1ps

// A load item (in_func = 0) writes one palette entry; busy stays low. A
// match item (in_func = 1) reads every palette entry once through the
// single read port of the palette memory, one entry per cycle, and then
// passes the last entry through the distance pipeline before the out_valid
// strobe. busy is high for the whole search. The result shows for exactly
// one cycle with out_valid and is not held: the receiver must take it
// then. Weights are to be written through the cfg port only while the
// block is idle; the block itself does not enforce this. cfg_ready is
// always high.

module weighted_nearest_palette_match
  import wnpm_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_func,
  input  logic [IDX_BITS-1:0]     in_color_index,
  input  logic [7:0]              in_red_value,
  input  logic [7:0]              in_green_value,
  input  logic [7:0]              in_blue_value,
  output logic                    out_valid,
  output logic [IDX_BITS-1:0]     out_best_index,
  output logic [DIST_BITS-1:0]    out_best_distance,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [WGT_BITS-1:0]     cfg_wdata
);

  localparam int unsigned AW = $clog2(PALETTE_ENTRIES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(PALETTE_ENTRIES - 1);

  state_t              state_r, state_nxt;
  logic [AW-1:0]       addr_r, addr_nxt;
  logic                out_valid_r, out_valid_nxt;
  weights_t            weights_r;
  rgb6_t               source_r;
  logic [IDX_BITS-1:0] src_idx_r;
  tag_t                rd_tag_r;
  rgb6_t               entry;
  prod_t               prod;
  logic [DIST_BITS-1:0] cand_dist;
  logic [DIST_BITS-1:0] best_dist_r;
  logic [IDX_BITS-1:0]  best_idx_r;
  logic                 take;
  logic                 accept;
  logic                 load_we;
  logic                 scan_re;

  assign accept  = start && !busy;
  assign load_we = accept && (func_t'(in_func) == FUNC_LOAD)
                   && ({1'b0, in_color_index} < 9'(PALETTE_ENTRIES));
  assign scan_re = (state_r == ST_SCAN);

  wnpm_palette_ram #(
    .DEPTH (PALETTE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (in_color_index[AW-1:0]),
    .wdata ({in_red_value[CH_BITS-1:0], in_green_value[CH_BITS-1:0],
             in_blue_value[CH_BITS-1:0]}),
    .re    (scan_re),
    .raddr (addr_r),
    .rdata (entry)
  );

  wnpm_dist u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .tag_in   (rd_tag_r),
    .entry    (entry),
    .source   (source_r),
    .weights  (weights_r),
    .prod_out (prod)
  );

  // state machine
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      addr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        addr_nxt = '0;
        if (accept && (func_t'(in_func) == FUNC_MATCH)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (addr_r == LAST_ADDR) begin
          state_nxt = ST_DRAIN;
        end else begin
          addr_nxt = addr_r + AW'(1);
        end
      end
      ST_DRAIN: begin
        if (prod.tag.valid && prod.tag.last) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // tag lines up with the registered read data of the palette memory
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_tag_r.valid <= 1'b0;
    end else begin
      rd_tag_r.valid <= scan_re;
    end
    rd_tag_r.first <= (addr_r == '0);
    rd_tag_r.last  <= (addr_r == LAST_ADDR);
    rd_tag_r.idx   <= IDX_BITS'(addr_r);
  end

  always_ff @(posedge clk) begin
    if (accept && (func_t'(in_func) == FUNC_MATCH)) begin
      source_r  <= {in_red_value[7:2], in_green_value[7:2], in_blue_value[7:2]};
      src_idx_r <= in_color_index;
    end
  end

  // weight registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weights_r.red   <= WGT_BITS'(1);
      weights_r.green <= WGT_BITS'(1);
      weights_r.blue  <= WGT_BITS'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RED_WEIGHT:   weights_r.red   <= cfg_wdata;
        REG_GREEN_WEIGHT: weights_r.green <= cfg_wdata;
        REG_BLUE_WEIGHT:  weights_r.blue  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // running best: the source index also wins a tie
  assign cand_dist = DIST_BITS'(prod.red) + DIST_BITS'(prod.green) + DIST_BITS'(prod.blue);

  always_comb begin
    take = prod.tag.first || (cand_dist < best_dist_r)
           || ((prod.tag.idx == src_idx_r) && (cand_dist == best_dist_r));
  end

  always_ff @(posedge clk) begin
    if (prod.tag.valid && take) begin
      best_dist_r <= cand_dist;
      best_idx_r  <= prod.tag.idx;
    end
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_best_index    = best_idx_r;
  assign out_best_distance = best_dist_r;

endmodule

// ===== hw/rtl/wnpm_checker.sv =====
// port-level checks for the weighted nearest palette match
// depends on wnpm_pkg; bound to the top level below
`timescale 1ns / 1ps

module wnpm_checker
  import wnpm_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    start,
  input logic                    busy,
  input logic                    in_func,
  input logic                    out_valid,
  input logic [DIST_BITS-1:0]    out_best_distance
);

  // a match transfer starts a search
  a_match_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_func == FUNC_MATCH)) |=> busy)
    else $error("match transfer did not raise busy");

  // a result only closes a search
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) && !busy))
    else $error("result strobe without a finished search");

  // a load never produces a result
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_func == FUNC_LOAD)) |=> !out_valid)
    else $error("result strobe after a load");

  // distance never exceeds the largest weighted 6-bit distance
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_best_distance <= MAX_DIST))
    else $error("distance out of range");

endmodule

bind weighted_nearest_palette_match wnpm_checker u_wnpm_checker (.*);

// ===== bench/tb_top.sv =====
// testbench for weighted_nearest_palette_match: palette loads, nearest-entry searches, weights
// depends on wnpm_pkg and the weighted_nearest_palette_match rtl only
`timescale 1ns / 1ps

module tb_top;
  import wnpm_pkg::*;

  localparam int unsigned ENTRIES     = 256;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned PHASE_ITEMS = 180;

  typedef struct packed {
    logic [IDX_BITS-1:0]  best_index;
    logic [DIST_BITS-1:0] best_distance;
  } match_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic in_func;
  logic [IDX_BITS-1:0] in_color_index;
  logic [7:0] in_red_value;
  logic [7:0] in_green_value;
  logic [7:0] in_blue_value;
  logic out_valid;
  logic [IDX_BITS-1:0] out_best_index;
  logic [DIST_BITS-1:0] out_best_distance;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [WGT_BITS-1:0] cfg_wdata;

  // predictor state
  rgb6_t    palette_model [ENTRIES];
  weights_t weight_model;
  match_result_t pending_matches [$];

  int unsigned sender_gap_pct = 36;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  weighted_nearest_palette_match #(
    .PALETTE_ENTRIES(ENTRIES)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_color_index   (in_color_index),
    .in_red_value     (in_red_value),
    .in_green_value   (in_green_value),
    .in_blue_value    (in_blue_value),
    .out_valid        (out_valid),
    .out_best_index   (out_best_index),
    .out_best_distance(out_best_distance),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[weighted_nearest_palette_match] ERROR");
      $finish;
    end
  end

  // full scan, first entry seeds the best, source index also wins a tie
  function automatic match_result_t find_nearest_entry(input logic [IDX_BITS-1:0] src_index,
                                                       input logic [7:0] red,
                                                       input logic [7:0] green,
                                                       input logic [7:0] blue);
    match_result_t best;
    rgb6_t src;
    int dr;
    int dg;
    int db;
    int unsigned cand_dist;
    int unsigned best_dist;
    bit take;
    best = '0;
    best_dist = 0;
    src.red = red[7:2];
    src.green = green[7:2];
    src.blue = blue[7:2];
    for (int e = 0; e < ENTRIES; e++) begin
      dr = int'(src.red) - int'(palette_model[e].red);
      dg = int'(src.green) - int'(palette_model[e].green);
      db = int'(src.blue) - int'(palette_model[e].blue);
      cand_dist = int'(weight_model.red) * dr * dr + int'(weight_model.green) * dg * dg
                + int'(weight_model.blue) * db * db;
      if (e == 0) begin
        take = 1'b1;
      end else if (e == int'(src_index)) begin
        take = (cand_dist <= best_dist);
      end else begin
        take = (cand_dist < best_dist);
      end
      if (take) begin
        best_dist = cand_dist;
        best.best_index = e[IDX_BITS-1:0];
      end
    end
    best.best_distance = best_dist[DIST_BITS-1:0];
    return best;
  endfunction

  task automatic send_item(input func_t func, input logic [IDX_BITS-1:0] index,
                           input logic [7:0] red, input logic [7:0] green,
                           input logic [7:0] blue);
    @(negedge clk);
    while ($urandom_range(99) < sender_gap_pct) begin
      start <= 1'b0;
      in_func <= 1'($urandom);
      in_color_index <= IDX_BITS'($urandom);
      in_red_value <= 8'($urandom);
      in_green_value <= 8'($urandom);
      in_blue_value <= 8'($urandom);
      @(negedge clk);
    end
    start <= 1'b1;
    in_func <= func;
    in_color_index <= index;
    in_red_value <= red;
    in_green_value <= green;
    in_blue_value <= blue;
    @(posedge clk);
    while (busy) @(posedge clk);
    // transfer done at this edge
    if (func == FUNC_LOAD) begin
      if (int'(index) < ENTRIES) begin
        palette_model[index] = '{red[5:0], green[5:0], blue[5:0]};
      end
    end else begin
      pending_matches.push_back(find_nearest_entry(index, red, green, blue));
    end
  endtask

  task automatic release_start();
    @(negedge clk);
    start <= 1'b0;
  endtask

  // loads leave nothing to wait for, so give a full search time after the last result
  task automatic wait_idle();
    release_start();
    while (pending_matches.size() != 0 || busy) @(posedge clk);
    repeat (ENTRIES + 8) @(posedge clk);
  endtask

  task automatic write_weight(input reg_idx_t which, input logic [WGT_BITS-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_wdata <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (which)
      REG_RED_WEIGHT:   weight_model.red = value;
      REG_GREEN_WEIGHT: weight_model.green = value;
      REG_BLUE_WEIGHT:  weight_model.blue = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_weights(input logic [WGT_BITS-1:0] red, input logic [WGT_BITS-1:0] green,
                             input logic [WGT_BITS-1:0] blue);
    write_weight(REG_RED_WEIGHT, red);
    write_weight(REG_GREEN_WEIGHT, green);
    write_weight(REG_BLUE_WEIGHT, blue);
  endtask

  function automatic logic [WGT_BITS-1:0] pick_weight();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return WGT_BITS'($urandom);
    endcase
  endfunction

  // every entry white, upper load bits random so they must be dropped
  task automatic test_fill_palette();
    logic [1:0] hr;
    logic [1:0] hg;
    logic [1:0] hb;
    for (int e = 0; e < ENTRIES; e++) begin
      hr = 2'($urandom);
      hg = 2'($urandom);
      hb = 2'($urandom);
      send_item(FUNC_LOAD, e[IDX_BITS-1:0], {hr, 6'h3F}, {hg, 6'h3F}, {hb, 6'h3F});
    end
  endtask

  // all entries tie, so the source index is picked; black source gives the top distance
  task automatic test_max_distance();
    wait_idle();
    set_weights(8'd255, 8'd255, 8'd255);
    send_item(FUNC_MATCH, 8'd77, 8'd0, 8'd0, 8'd0);
    send_item(FUNC_MATCH, 8'd0, 8'd3, 8'd2, 8'd1);
    send_item(FUNC_MATCH, 8'd255, 8'd0, 8'd0, 8'd0);
    send_item(FUNC_MATCH, 8'd200, 8'hFF, 8'hFF, 8'hFF);
  endtask

  task automatic test_tie_preference();
    wait_idle();
    set_weights(8'd1, 8'd1, 8'd1);
    send_item(FUNC_LOAD, 8'd0, {2'b10, 6'd5}, {2'b01, 6'd5}, {2'b11, 6'd5});
    send_item(FUNC_LOAD, 8'd10, 8'd20, 8'd30, 8'd40);
    send_item(FUNC_LOAD, 8'd200, 8'd20, 8'd30, 8'd40);
    send_item(FUNC_LOAD, 8'd255, 8'd63, 8'd0, 8'd63);
    // duplicates: earlier one wins unless the source index points at the later one
    send_item(FUNC_MATCH, 8'd5, 8'd80, 8'd120, 8'd160);
    send_item(FUNC_MATCH, 8'd200, 8'd80, 8'd120, 8'd160);
    send_item(FUNC_MATCH, 8'd10, 8'd83, 8'd121, 8'd163);
    send_item(FUNC_MATCH, 8'd0, 8'd252, 8'd2, 8'd255);
    send_item(FUNC_MATCH, 8'd255, 8'd20, 8'd20, 8'd20);
    send_item(FUNC_MATCH, 8'd0, 8'hFF, 8'hFF, 8'hFF);
  endtask

  task automatic test_weight_extremes();
    wait_idle();
    set_weights(8'd0, 8'd0, 8'd0);
    send_item(FUNC_MATCH, 8'd123, 8'd17, 8'd200, 8'd99);
    send_item(FUNC_MATCH, 8'd0, 8'd255, 8'd0, 8'd255);
    wait_idle();
    set_weights(8'd255, 8'd0, 8'd1);
    send_item(FUNC_MATCH, 8'd10, 8'd0, 8'd255, 8'd255);
    wait_idle();
    set_weights(8'd0, 8'd255, 8'd0);
    send_item(FUNC_MATCH, 8'd200, 8'd255, 8'd0, 8'd128);
    send_item(FUNC_MATCH, 8'd1, 8'd90, 8'd255, 8'd0);
  endtask

  task automatic send_random_item();
    logic [IDX_BITS-1:0] idx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    rgb6_t pick;
    int unsigned kind;
    kind = $urandom_range(99);
    idx = IDX_BITS'($urandom);
    red = 8'($urandom);
    green = 8'($urandom);
    blue = 8'($urandom);
    if (kind < 20) begin
      // copy a stored color to make duplicate entries
      pick = palette_model[IDX_BITS'($urandom_range(ENTRIES - 1))];
      send_item(FUNC_LOAD, idx, {red[7:6], pick.red}, {green[7:6], pick.green},
                {blue[7:6], pick.blue});
    end else if (kind < 45) begin
      send_item(FUNC_LOAD, idx, red, green, blue);
    end else if (kind < 75) begin
      // exact hit on the source entry, ties with duplicates go its way
      pick = palette_model[idx];
      send_item(FUNC_MATCH, idx, {pick.red, red[1:0]}, {pick.green, green[1:0]},
                {pick.blue, blue[1:0]});
    end else begin
      send_item(FUNC_MATCH, idx, red, green, blue);
    end
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      wait_idle();
      set_weights(pick_weight(), pick_weight(), pick_weight());
      sender_gap_pct = (phase < 2) ? 36 : (phase < 4) ? 85 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_random_item();
      end
    end
  endtask

  always @(posedge clk) begin
    match_result_t want;
    if (rst_n && out_valid) begin
      if (pending_matches.size() == 0) begin
        $display("%0t: result with none expected: index %0d distance %0d", $time,
                 out_best_index, out_best_distance);
        error_count++;
      end else begin
        want = pending_matches.pop_front();
        if (out_best_index !== want.best_index) begin
          $display("%0t: best_index expected %0d actual %0d", $time, want.best_index,
                   out_best_index);
          error_count++;
        end
        if (out_best_distance !== want.best_distance) begin
          $display("%0t: best_distance expected %0d actual %0d", $time, want.best_distance,
                   out_best_distance);
          error_count++;
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_func = FUNC_LOAD;
    in_color_index = '0;
    in_red_value = '0;
    in_green_value = '0;
    in_blue_value = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_RED_WEIGHT;
    cfg_wdata = '0;
    weight_model = '{8'd1, 8'd1, 8'd1};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_fill_palette();
    test_max_distance();
    test_tie_preference();
    test_weight_extremes();
    test_random_traffic();

    wait_idle();
    if (error_count == 0) begin
      $display("[weighted_nearest_palette_match] OK");
    end else begin
      $display("[weighted_nearest_palette_match] ERROR");
    end
    $finish;
  end

endmodule
